@@ hw/rtl/pps_pkg.sv @@
`default_nettype none

package pps_pkg;

  // Default size of the process table.
  localparam int unsigned NumSlotsDef = 16;

  localparam int unsigned IdW    = 8;
  localparam int unsigned BurstW = 16;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned StatW  = 2;

  // Result status codes.
  localparam logic [StatW-1:0] StatDone = 2'd0;
  localparam logic [StatW-1:0] StatFull = 2'd1;
  localparam logic [StatW-1:0] StatZero = 2'd2;

  // One entry of the process table.
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [BurstW-1:0] remaining;
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  prio;
    logic [TimeW-1:0]  arrival;
  } slot_t;

endpackage

`default_nettype wire

@@ hw/rtl/preemptive_priority_scheduler.sv @@
`default_nettype none

// Preemptive priority scheduler over a table of NUM_SLOTS process slots.
// An arrive word (mode 0) stores a process in the lowest free slot, stamped
// with the current time; a zero burst or a full table is answered with a
// reject word instead. A tick word (mode 1) serves one time unit to the ready
// process with the smallest priority (ties: earliest arrival, then lowest
// slot) and advances time; a finishing process yields one completion word.
// The block handles one input word at a time and holds in_stall high while
// busy. The table sits in a memory with one write port and one registered
// read port, and one comparator walks it one slot per cycle. An arrive probes
// one slot per cycle up to the first free one. A result that finds the output
// register still held waits until that word is taken. A finished word waits
// in the output register while the next input word is taken.
module preemptive_priority_scheduler #(
  parameter int unsigned NUM_SLOTS = pps_pkg::NumSlotsDef
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_mode,
  input  wire logic [pps_pkg::IdW-1:0]    in_process_id,
  input  wire logic [pps_pkg::BurstW-1:0] in_burst_time,
  input  wire logic [pps_pkg::PrioW-1:0]  in_priority_req,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [pps_pkg::StatW-1:0]       out_status,
  output logic [pps_pkg::IdW-1:0]         out_done_id,
  output logic [pps_pkg::TimeW-1:0]       out_finish_time,
  output logic [pps_pkg::TimeW-1:0]       out_turnaround_time,
  output logic [pps_pkg::TimeW-1:0]       out_waiting_time
);

  localparam int unsigned IdxW = $clog2(NUM_SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,   // wait for an input word
    S_FREE,   // probe valid bits for the lowest free slot
    S_SCAN,   // issue table reads, compare the previous slot
    S_DRAIN,  // compare the last slot read
    S_UPD,    // charge the winner one tick, advance time
    S_WT,     // waiting time from turnaround
    S_EMIT    // move the result into the output register
  } state_t;

  state_t state_r;

  // Valid bits live in flops so a free slot reads as empty right after reset.
  logic [NUM_SLOTS-1:0]        valid_r;
  logic [IdxW-1:0]             cnt_r;
  logic [pps_pkg::TimeW-1:0]   time_r;

  // Latched arrive request.
  logic [pps_pkg::IdW-1:0]     req_id_r;
  logic [pps_pkg::BurstW-1:0]  req_burst_r;
  logic [pps_pkg::PrioW-1:0]   req_prio_r;

  // Compare pipeline: slot pipe_idx_r is on the memory read data.
  logic                        pipe_vld_r;
  logic [IdxW-1:0]             pipe_idx_r;

  // Pending result.
  logic [pps_pkg::StatW-1:0]   res_status_r;
  logic [pps_pkg::IdW-1:0]     res_id_r;
  logic [pps_pkg::TimeW-1:0]   res_fin_r;
  logic [pps_pkg::TimeW-1:0]   res_ta_r;
  logic [pps_pkg::TimeW-1:0]   res_wt_r;

  // Output register.
  logic                        out_valid_r;
  logic [pps_pkg::StatW-1:0]   out_status_r;
  logic [pps_pkg::IdW-1:0]     out_id_r;
  logic [pps_pkg::TimeW-1:0]   out_fin_r;
  logic [pps_pkg::TimeW-1:0]   out_ta_r;
  logic [pps_pkg::TimeW-1:0]   out_wt_r;

  logic                        in_acc;
  logic                        out_load;
  logic [pps_pkg::TimeW-1:0]   time_inc;
  logic [pps_pkg::BurstW-1:0]  rem_dec;

  logic                        mem_we;
  logic [IdxW-1:0]             mem_waddr;
  pps_pkg::slot_t              mem_wdata;
  pps_pkg::slot_t              mem_rdata;

  logic                        found;
  logic [IdxW-1:0]             best_idx;
  pps_pkg::slot_t              best;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign time_inc = time_r + pps_pkg::TimeW'(1);
  assign rem_dec  = best.remaining - pps_pkg::BurstW'(1);

  // Single write port: new process on arrive, decremented burst on tick.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_idx;
    mem_wdata = best;
    if (state_r == S_FREE) begin
      mem_we              = !valid_r[cnt_r];
      mem_waddr           = cnt_r;
      mem_wdata.id        = req_id_r;
      mem_wdata.remaining = req_burst_r;
      mem_wdata.burst     = req_burst_r;
      mem_wdata.prio      = req_prio_r;
      mem_wdata.arrival   = time_r;
    end else if (state_r == S_UPD) begin
      mem_we              = found && (rem_dec != '0);
      mem_wdata.remaining = rem_dec;
    end
  end

  pps_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cnt_r),
    .rdata (mem_rdata)
  );

  pps_best_sel #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_sel (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (in_acc),
    .cand_vld (pipe_vld_r),
    .cand_idx (pipe_idx_r),
    .cand     (mem_rdata),
    .found    (found),
    .best_idx (best_idx),
    .best     (best)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      time_r      <= '0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Read of slot cnt_r lands next cycle; tag it with its valid bit.
      pipe_vld_r <= (state_r == S_SCAN) && valid_r[cnt_r];

      // Drop the output word once taken, unless a new one loads below.
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_id_r    <= in_process_id;
            req_burst_r <= in_burst_time;
            req_prio_r  <= in_priority_req;
            cnt_r       <= '0;
            if (in_mode) begin
              state_r <= S_SCAN;
            end else if (in_burst_time == '0) begin
              res_status_r <= pps_pkg::StatZero;
              res_id_r     <= in_process_id;
              res_fin_r    <= '0;
              res_ta_r     <= '0;
              res_wt_r     <= '0;
              state_r      <= S_EMIT;
            end else begin
              state_r <= S_FREE;
            end
          end
        end

        S_FREE: begin
          if (!valid_r[cnt_r]) begin
            valid_r[cnt_r] <= 1'b1;
            state_r        <= S_IDLE;
          end else if (cnt_r == LastIdx) begin
            res_status_r <= pps_pkg::StatFull;
            res_id_r     <= req_id_r;
            res_fin_r    <= '0;
            res_ta_r     <= '0;
            res_wt_r     <= '0;
            state_r      <= S_EMIT;
          end else begin
            cnt_r <= cnt_r + IdxW'(1);
          end
        end

        S_SCAN: begin
          pipe_idx_r <= cnt_r;
          if (cnt_r == LastIdx) begin
            state_r <= S_DRAIN;
          end else begin
            cnt_r <= cnt_r + IdxW'(1);
          end
        end

        S_DRAIN: begin
          state_r <= S_UPD;
        end

        S_UPD: begin
          time_r  <= time_inc;
          state_r <= S_IDLE;
          if (found && (rem_dec == '0)) begin
            valid_r[best_idx] <= 1'b0;
            res_status_r      <= pps_pkg::StatDone;
            res_id_r          <= best.id;
            res_fin_r         <= time_inc;
            res_ta_r          <= time_inc - best.arrival;
            state_r           <= S_WT;
          end
        end

        S_WT: begin
          res_wt_r <= res_ta_r - pps_pkg::TimeW'(best.burst);
          state_r  <= S_EMIT;
        end

        S_EMIT: begin
          // Hold until the output register is free or being emptied.
          if (out_load) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_id_r     <= res_id_r;
            out_fin_r    <= res_fin_r;
            out_ta_r     <= res_ta_r;
            out_wt_r     <= res_wt_r;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_done_id         = out_id_r;
  assign out_finish_time     = out_fin_r;
  assign out_turnaround_time = out_ta_r;
  assign out_waiting_time    = out_wt_r;

endmodule

`default_nettype wire

@@ hw/rtl/pps_slot_mem.sv @@
`default_nettype none

module pps_slot_mem #(
  parameter int unsigned NUM_SLOTS = pps_pkg::NumSlotsDef,
  localparam int unsigned IdxW     = $clog2(NUM_SLOTS)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IdxW-1:0]  waddr,
  input  wire pps_pkg::slot_t   wdata,
  input  wire logic [IdxW-1:0]  raddr,
  output pps_pkg::slot_t        rdata
);

  pps_pkg::slot_t mem [NUM_SLOTS];
  pps_pkg::slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/pps_best_sel.sv @@
`default_nettype none

module pps_best_sel #(
  parameter int unsigned NUM_SLOTS = pps_pkg::NumSlotsDef,
  localparam int unsigned IdxW     = $clog2(NUM_SLOTS)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             clr,
  input  wire logic             cand_vld,
  input  wire logic [IdxW-1:0]  cand_idx,
  input  wire pps_pkg::slot_t   cand,
  output logic                  found,
  output logic [IdxW-1:0]       best_idx,
  output pps_pkg::slot_t        best
);

  logic           found_r;
  logic [IdxW-1:0] best_idx_r;
  pps_pkg::slot_t best_r;
  logic           take;

  // Strictly better only: a later slot with equal key never displaces the
  // current best, which gives the lowest-slot tie break.
  always_comb begin
    take = cand_vld && (!found_r || (cand.prio < best_r.prio) ||
           ((cand.prio == best_r.prio) && (cand.arrival < best_r.arrival)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
    if (take) begin
      best_idx_r <= cand_idx;
      best_r     <= cand;
    end
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;
  assign best     = best_r;

endmodule

`default_nettype wire

@@ dv/preemptive_priority_scheduler_test.sv @@
`default_nettype none

module preemptive_priority_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  localparam int unsigned NumSlots = NumSlotsDef;

  // Input word modes.
  localparam logic ModeArrive = 1'b0;
  localparam logic ModeTick   = 1'b1;

  // Length of the long receiver hold that backs the block up to its input.
  localparam int unsigned HoldCycles = 300;
  // Input word budget for the whole run.
  localparam int unsigned WordBudget = 1100;

  // One result word as the block reports it.
  typedef struct packed {
    logic [StatW-1:0] status;
    logic [IdW-1:0]   done_id;
    logic [TimeW-1:0] fin_time;
    logic [TimeW-1:0] turnaround;
    logic [TimeW-1:0] waiting;
  } sched_report_t;

  logic                clk;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic                in_mode         = ModeTick;
  logic [IdW-1:0]      in_process_id   = '0;
  logic [BurstW-1:0]   in_burst_time   = '0;
  logic [PrioW-1:0]    in_priority_req = '0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [StatW-1:0]    out_status;
  logic [IdW-1:0]      out_done_id;
  logic [TimeW-1:0]    out_finish_time;
  logic [TimeW-1:0]    out_turnaround_time;
  logic [TimeW-1:0]    out_waiting_time;

  // Shadow copy of the process table and the scheduler clock.
  logic                slot_busy [NumSlots];
  slot_t               slot_tab  [NumSlots];
  logic [TimeW-1:0]    sched_now;

  // Reports the block still owes us, oldest first.
  sched_report_t       expected_reports [$];

  int                  mismatches = 0;
  int                  words_sent = 0;
  bit                  tx_idle_en = 1'b0;
  bit                  rx_idle_en = 1'b0;
  bit                  hold_out   = 1'b0;

  preemptive_priority_scheduler #(
    .NUM_SLOTS(NumSlots)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_process_id      (in_process_id),
    .in_burst_time      (in_burst_time),
    .in_priority_req    (in_priority_req),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_done_id        (out_done_id),
    .out_finish_time    (out_finish_time),
    .out_turnaround_time(out_turnaround_time),
    .out_waiting_time   (out_waiting_time)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up well past the slowest legal run: every tick word at full table
  // scan plus completion, every word behind the longest sender gap and
  // receiver stall, plus the long hold.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Apply one accepted word to the shadow table. Return 1 and fill rpt when
  // the word causes a report.
  function automatic bit schedule_word(input logic mode, input logic [IdW-1:0] pid,
                                       input logic [BurstW-1:0] burst,
                                       input logic [PrioW-1:0] prio,
                                       output sched_report_t rpt);
    int               best;
    bit               found;
    logic [TimeW-1:0] tat;
    rpt   = '0;
    best  = 0;
    found = 1'b0;
    if (mode == ModeArrive) begin
      rpt.done_id = pid;
      // A zero burst is refused before the table is even looked at.
      if (burst == '0) begin
        rpt.status = StatZero;
        return 1'b1;
      end
      // Take the lowest free slot and stamp it with the current time.
      for (int i = 0; i < NumSlots; i++) begin
        if (!slot_busy[i]) begin
          slot_busy[i] = 1'b1;
          slot_tab[i]  = '{id: pid, remaining: burst, burst: burst, prio: prio,
                           arrival: sched_now};
          return 1'b0;
        end
      end
      rpt.status = StatFull;
      return 1'b1;
    end
    // Tick: smallest priority wins, then the earlier stamp, then the lower slot
    // (strict compares keep the first slot found on a full tie).
    for (int i = 0; i < NumSlots; i++) begin
      if (slot_busy[i]) begin
        if (!found || slot_tab[i].prio < slot_tab[best].prio ||
            (slot_tab[i].prio == slot_tab[best].prio &&
             slot_tab[i].arrival < slot_tab[best].arrival)) begin
          found = 1'b1;
          best  = i;
        end
      end
    end
    sched_now = sched_now + 1'b1;
    if (!found) return 1'b0;
    slot_tab[best].remaining = slot_tab[best].remaining - 1'b1;
    if (slot_tab[best].remaining != '0) return 1'b0;
    tat = sched_now - slot_tab[best].arrival;
    rpt = '{status: StatDone, done_id: slot_tab[best].id, fin_time: sched_now,
            turnaround: tat, waiting: tat - TimeW'(slot_tab[best].burst)};
    slot_busy[best] = 1'b0;
    return 1'b1;
  endfunction

  // Offer one word and hold it until the block takes it. Valid is only
  // dropped when a sender gap opens, so back-to-back words keep it high.
  task automatic send_word(input logic mode, input logic [IdW-1:0] pid,
                           input logic [BurstW-1:0] burst, input logic [PrioW-1:0] prio);
    sched_report_t rpt;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_process_id   <= pid;
    in_burst_time   <= burst;
    in_priority_req <= prio;
    // in_stall read right after the edge is the value the edge saw.
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (schedule_word(mode, pid, burst, prio, rpt))
      expected_reports.insert(expected_reports.size(), rpt);
  endtask

  // Compare one accepted report with the oldest one owed.
  task automatic check_report();
    sched_report_t got;
    sched_report_t want;
    got = '{status: out_status, done_id: out_done_id, fin_time: out_finish_time,
            turnaround: out_turnaround_time, waiting: out_waiting_time};
    if (expected_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: report with none owed: st=%0d id=%0h fin=%0d ta=%0d wt=%0d",
                 $realtime, got.status, got.done_id, got.fin_time, got.turnaround,
                 got.waiting);
      return;
    end
    want = expected_reports.pop_front();
    if (got.status !== want.status || got.done_id !== want.done_id ||
        got.fin_time !== want.fin_time || got.turnaround !== want.turnaround ||
        got.waiting !== want.waiting) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: report differs: exp st=%0d id=%0h fin=%0d ta=%0d wt=%0d, %s",
                 $realtime, want.status, want.done_id, want.fin_time, want.turnaround,
                 want.waiting,
                 $sformatf("got st=%0d id=%0h fin=%0d ta=%0d wt=%0d", got.status,
                           got.done_id, got.fin_time, got.turnaround, got.waiting));
    end
  endtask

  // Sample the result port on every edge; values read here are pre-edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_report();
  end

  // Receiver side: short random stall bursts, or one long hold on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        hold_out = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Zero-burst arrival is refused with its id; a tick on an empty table only
  // moves time forward.
  task automatic test_zero_burst();
    send_word(ModeArrive, 8'hFF, '0, 8'hFF);
    send_word(ModeTick, IdW'($urandom), BurstW'($urandom), PrioW'($urandom));
  endtask

  // Priority, tie breaking, preemption and duplicate ids.
  task automatic test_priority_order();
    send_word(ModeArrive, 8'h00, 16'd2, 8'h40);
    send_word(ModeArrive, 8'h07, 16'd1, 8'h10);
    // Same id, priority and stamp as the one above: lower slot must win.
    send_word(ModeArrive, 8'h07, 16'd2, 8'h10);
    send_word(ModeTick, IdW'($urandom), BurstW'($urandom), PrioW'($urandom));
    // Priority zero arrives and is served ahead of the waiting processes.
    send_word(ModeArrive, 8'hFF, 16'd1, 8'h00);
    repeat (5) send_word(ModeTick, IdW'($urandom), BurstW'($urandom), PrioW'($urandom));
  endtask

  // Fill every slot, then knock on a full table with a good and a zero burst.
  task automatic test_table_full();
    // This one lingers for the rest of the run at the lowest priority.
    send_word(ModeArrive, 8'hA5, 16'hFFFF, 8'hFF);
    for (int i = 1; i < NumSlots; i++)
      send_word(ModeArrive, IdW'(i), 16'd1, PrioW'(i * 16));
    send_word(ModeArrive, 8'hC3, 16'h8000, 8'h00);
    // Zero burst is reported as such even though the table is full.
    send_word(ModeArrive, 8'h3C, '0, 8'h00);
  endtask

  // Hold the result port for a long stretch while words keep coming, so the
  // output register fills and the block has to stall its input.
  task automatic test_output_backpressure();
    hold_out = 1'b1;
    repeat (4) send_word(ModeArrive, IdW'($urandom), '0, PrioW'($urandom));
    send_word(ModeArrive, IdW'($urandom), 16'd3, PrioW'($urandom));
    repeat (3) send_word(ModeTick, IdW'($urandom), BurstW'($urandom), PrioW'($urandom));
    wait (!hold_out);
  endtask

  // One burst of arrivals with random content, then roughly enough ticks to
  // serve them, so the table fills and drains over and over.
  task automatic random_batch();
    int                work;
    int                n_ticks;
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  prio;
    work = 0;
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 19))
        0:       burst = '0;
        1, 2:    burst = BurstW'($urandom_range(1, 40));
        default: burst = BurstW'($urandom_range(1, 6));
      endcase
      // Half the time crowd a few priorities together to force ties.
      prio = $urandom_range(0, 1) ? PrioW'($urandom) : PrioW'($urandom_range(0, 3));
      work += burst;
      send_word(ModeArrive, IdW'($urandom), burst, prio);
    end
    n_ticks = $urandom_range(work * 3 / 4, work + 4);
    repeat (n_ticks)
      send_word(ModeTick, IdW'($urandom), BurstW'($urandom), PrioW'($urandom));
  endtask

  // Random traffic with idling that comes and goes in stretches.
  task automatic test_random_traffic(input int unsigned stop_at);
    while (words_sent < stop_at) begin
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      repeat (4) random_batch();
    end
  endtask

  // Same traffic with both sides always ready.
  task automatic test_full_rate(input int unsigned stop_at);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (words_sent < stop_at) random_batch();
  endtask

  initial begin
    for (int i = 0; i < NumSlots; i++) begin
      slot_busy[i] = 1'b0;
      slot_tab[i]  = '0;
    end
    sched_now = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_burst();
    test_priority_order();
    test_table_full();
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
    test_output_backpressure();
    test_random_traffic(WordBudget - 150);
    test_full_rate(WordBudget);
    in_valid <= 1'b0;

    // Drain what is still owed, then watch a little longer for strays.
    for (int n = 0; n < 4000 && expected_reports.size() != 0; n++) @(posedge clk);
    repeat (4 * NumSlots) @(posedge clk);

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
